// ===== hdl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Types, character codes and widths shared by the escape decoder files.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int CHAR_IN_W  = 21;
   localparam int CHAR_OUT_W = 32;
   localparam int DIGIT_W    = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // character codes seen on the input
   localparam logic [CHAR_IN_W-1:0] CH_BACKSLASH = 21'h5C;
   localparam logic [CHAR_IN_W-1:0] CH_LBRACE    = 21'h7B;
   localparam logic [CHAR_IN_W-1:0] CH_RBRACE    = 21'h7D;
   localparam logic [CHAR_IN_W-1:0] CH_DIG_0     = 21'h30;
   localparam logic [CHAR_IN_W-1:0] CH_DIG_7     = 21'h37;
   localparam logic [CHAR_IN_W-1:0] CH_DIG_9     = 21'h39;
   localparam logic [CHAR_IN_W-1:0] CH_UP_A      = 21'h41;
   localparam logic [CHAR_IN_W-1:0] CH_UP_F      = 21'h46;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_A     = 21'h61;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_B     = 21'h62;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_E     = 21'h65;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_F     = 21'h66;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_N     = 21'h6E;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_R     = 21'h72;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_T     = 21'h74;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_V     = 21'h76;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_X     = 21'h78;
   localparam logic [CHAR_IN_W-1:0] CH_UP_X      = 21'h58;
   localparam logic [CHAR_IN_W-1:0] CH_LOW_U     = 21'h75;
   localparam logic [CHAR_IN_W-1:0] CH_UP_U      = 21'h55;

   // control codes produced by letter escapes
   localparam logic [CHAR_OUT_W-1:0] CODE_BEL = 32'd7;
   localparam logic [CHAR_OUT_W-1:0] CODE_BS  = 32'd8;
   localparam logic [CHAR_OUT_W-1:0] CODE_HT  = 32'd9;
   localparam logic [CHAR_OUT_W-1:0] CODE_LF  = 32'd10;
   localparam logic [CHAR_OUT_W-1:0] CODE_VT  = 32'd11;
   localparam logic [CHAR_OUT_W-1:0] CODE_FF  = 32'd12;
   localparam logic [CHAR_OUT_W-1:0] CODE_CR  = 32'd13;
   localparam logic [CHAR_OUT_W-1:0] CODE_ESC = 32'd27;

   localparam logic [DIGIT_W-1:0] DIGITS_X = 4'd2;
   localparam logic [DIGIT_W-1:0] DIGITS_U = 4'd4;
   localparam logic [DIGIT_W-1:0] DIGITS_W = 4'd8;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ESC      = 3'd1,
      MODE_OCT      = 3'd2,
      MODE_HEXSEL   = 3'd3,
      MODE_HEXFIX   = 3'd4,
      MODE_HEXBRACE = 3'd5
   } mode_type;

   typedef struct packed {
      mode_type                  mode;
      logic [CHAR_OUT_W-1:0]     acc;
      logic [DIGIT_W-1:0]        digits;
   } dec_state_type;

   typedef struct packed {
      logic [CHAR_OUT_W-1:0] char_out;
      logic                  char_valid;
      logic                  token_end;
   } rsp_word_type;

endpackage

// ===== hdl/esd_req_if.sv =====
// ----------------------------------------------------------------------------
// esd_req_if
// Valid/ready channel carrying one input character per word.
// ----------------------------------------------------------------------------
interface esd_req_if;
   import esd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_IN_W-1:0] char_in;
   logic                 token_last;

   modport source (output valid, output char_in, output token_last, input ready);
   modport sink   (input valid, input char_in, input token_last, output ready);

endinterface

// ===== hdl/esd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// esd_rsp_if
// Valid/ready channel carrying one decoded character per word.
// ----------------------------------------------------------------------------
interface esd_rsp_if;
   import esd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CHAR_OUT_W-1:0] char_out;
   logic                  char_valid;
   logic                  token_end;

   modport source (output valid, output char_out, output char_valid, output token_end,
                   input ready);
   modport sink   (input valid, input char_out, input char_valid, input token_end,
                   output ready);

endinterface

// ===== hdl/esd_decode.sv =====
// ----------------------------------------------------------------------------
// esd_decode
// Next-state and result logic for one character: up to two result words.
// ----------------------------------------------------------------------------
module esd_decode (
   input  logic                           enable,
   input  logic [esd_pkg::CHAR_IN_W-1:0]  char_in,
   input  logic                           token_last,
   input  esd_pkg::dec_state_type         cur,
   output esd_pkg::dec_state_type         nxt,
   output logic [1:0]                     word_cnt,
   output esd_pkg::rsp_word_type          word0,
   output esd_pkg::rsp_word_type          word1
);
   import esd_pkg::*;

   logic                  is_oct;
   logic                  is_hex;
   logic [DIGIT_W-1:0]    hex_d;
   logic [CHAR_OUT_W-1:0] char_ext;
   logic [CHAR_OUT_W-1:0] hex_acc;
   logic [DIGIT_W-1:0]    digits_dec;

   always_comb begin
      is_oct = (char_in >= CH_DIG_0) && (char_in <= CH_DIG_7);
      is_hex = 1'b0;
      hex_d  = char_in[3:0];
      if ((char_in >= CH_DIG_0) && (char_in <= CH_DIG_9)) begin
         is_hex = 1'b1;
      end else if (((char_in >= CH_UP_A) && (char_in <= CH_UP_F)) ||
                   ((char_in >= CH_LOW_A) && (char_in <= CH_LOW_F))) begin
         is_hex = 1'b1;
         hex_d  = char_in[3:0] + 4'd9;
      end
   end

   assign char_ext   = {{(CHAR_OUT_W-CHAR_IN_W){1'b0}}, char_in};
   assign hex_acc    = {cur.acc[CHAR_OUT_W-5:0], hex_d};
   assign digits_dec = cur.digits - 4'd1;

   logic                  flush_en;
   logic [CHAR_OUT_W-1:0] flush_val;
   logic                  chr_en;
   logic [CHAR_OUT_W-1:0] chr_val;
   logic                  plain_req;
   logic                  pend_en;
   logic [CHAR_OUT_W-1:0] pend_val;
   dec_state_type         stp;

   // candidate words in output order: flushed value, character, pending value
   rsp_word_type          cand [3];
   logic [2:0]            cand_en;
   logic [1:0]            cnt;
   rsp_word_type          w0;
   rsp_word_type          w1;

   always_comb begin
      stp       = cur;
      flush_en  = 1'b0;
      flush_val = cur.acc;
      chr_en    = 1'b0;
      chr_val   = char_ext;
      plain_req = 1'b0;

      if (!enable) begin
         stp.mode   = MODE_NORMAL;
         stp.acc    = '0;
         stp.digits = '0;
         chr_en     = 1'b1;
      end else begin
         unique case (cur.mode)
            MODE_ESC: begin
               stp.acc  = '0;
               stp.mode = MODE_NORMAL;
               unique case (char_in) inside
                  CH_LOW_A: begin chr_en = 1'b1; chr_val = CODE_BEL; end
                  CH_LOW_B: begin chr_en = 1'b1; chr_val = CODE_BS;  end
                  CH_LOW_E: begin chr_en = 1'b1; chr_val = CODE_ESC; end
                  CH_LOW_F: begin chr_en = 1'b1; chr_val = CODE_FF;  end
                  CH_LOW_N: begin chr_en = 1'b1; chr_val = CODE_LF;  end
                  CH_LOW_R: begin chr_en = 1'b1; chr_val = CODE_CR;  end
                  CH_LOW_T: begin chr_en = 1'b1; chr_val = CODE_HT;  end
                  CH_LOW_V: begin chr_en = 1'b1; chr_val = CODE_VT;  end
                  CH_LOW_X, CH_UP_X: begin
                     stp.digits = DIGITS_X;
                     stp.mode   = MODE_HEXSEL;
                  end
                  CH_LOW_U: begin
                     stp.digits = DIGITS_U;
                     stp.mode   = MODE_HEXSEL;
                  end
                  CH_UP_U: begin
                     stp.digits = DIGITS_W;
                     stp.mode   = MODE_HEXSEL;
                  end
                  default: begin
                     if (is_oct) begin
                        stp.acc  = {{(CHAR_OUT_W-3){1'b0}}, char_in[2:0]};
                        stp.mode = MODE_OCT;
                     end else begin
                        chr_en = 1'b1;
                     end
                  end
               endcase
            end
            MODE_OCT: begin
               if (is_oct) begin
                  stp.acc = {cur.acc[CHAR_OUT_W-4:0], char_in[2:0]};
               end else begin
                  flush_en  = 1'b1;
                  stp.acc   = '0;
                  plain_req = 1'b1;
               end
            end
            MODE_HEXSEL, MODE_HEXFIX: begin
               if ((cur.mode == MODE_HEXSEL) && (char_in == CH_LBRACE)) begin
                  stp.mode = MODE_HEXBRACE;
               end else if (is_hex && (cur.digits != '0)) begin
                  stp.digits = digits_dec;
                  if (digits_dec == '0) begin
                     flush_en  = 1'b1;
                     flush_val = hex_acc;
                     stp.acc   = '0;
                     stp.mode  = MODE_NORMAL;
                  end else begin
                     stp.acc  = hex_acc;
                     stp.mode = MODE_HEXFIX;
                  end
               end else begin
                  flush_en  = 1'b1;
                  stp.acc   = '0;
                  plain_req = 1'b1;
               end
            end
            MODE_HEXBRACE: begin
               if (is_hex) begin
                  stp.acc = hex_acc;
               end else begin
                  flush_en = 1'b1;
                  stp.acc  = '0;
                  if (char_in == CH_RBRACE) begin
                     stp.mode = MODE_NORMAL;
                  end else begin
                     plain_req = 1'b1;
                  end
               end
            end
            default: begin
               plain_req = 1'b1;
            end
         endcase

         if (plain_req) begin
            if (char_in == CH_BACKSLASH) begin
               stp.mode = MODE_ESC;
            end else begin
               stp.mode = MODE_NORMAL;
               chr_en   = 1'b1;
            end
         end
      end

      // end of token flushes any value still being built
      pend_en  = token_last && ((stp.mode == MODE_OCT) || (stp.mode == MODE_HEXSEL) ||
                                (stp.mode == MODE_HEXFIX) || (stp.mode == MODE_HEXBRACE));
      pend_val = stp.acc;

      nxt = stp;
      if (token_last) begin
         nxt.mode   = MODE_NORMAL;
         nxt.acc    = '0;
         nxt.digits = '0;
      end
   end

   always_comb begin
      cand[0] = '{char_out: flush_val, char_valid: 1'b1, token_end: 1'b0};
      cand[1] = '{char_out: chr_val,   char_valid: 1'b1, token_end: 1'b0};
      cand[2] = '{char_out: pend_val,  char_valid: 1'b1, token_end: 1'b0};
      cand_en = {pend_en, chr_en, flush_en};
      cnt = 2'd0;
      w0  = '0;
      w1  = '0;
      for (int i = 0; i < 3; i++) begin
         if (cand_en[i] && (cnt != 2'd2)) begin
            if (cnt == 2'd0) begin
               w0 = cand[i];
            end else begin
               w1 = cand[i];
            end
            cnt = cnt + 2'd1;
         end
      end
      if (token_last) begin
         if (cnt == 2'd0) begin
            // bare end mark
            w0.token_end = 1'b1;
            cnt = 2'd1;
         end else if (cnt == 2'd1) begin
            w0.token_end = 1'b1;
         end else begin
            w1.token_end = 1'b1;
         end
      end
   end

   assign word_cnt = cnt;
   assign word0    = w0;
   assign word1    = w1;

endmodule

// ===== hdl/esd_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// esd_rsp_queue
// Small result queue: takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
module esd_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      push_cnt,
   input  esd_pkg::rsp_word_type           push0,
   input  esd_pkg::rsp_word_type           push1,
   input  logic                            pop,
   output esd_pkg::rsp_word_type           head,
   output logic [esd_pkg::QUEUE_CNT_W-1:0] count
);
   import esd_pkg::*;

   rsp_word_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic [QUEUE_PTR_W-1:0] wr_ptr_p1;

   assign wr_ptr_p1 = wr_ptr_ff + QUEUE_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + push_cnt[QUEUE_PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(pop);
   assign count_in  = count_ff + QUEUE_CNT_W'(push_cnt) - QUEUE_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// ===== hdl/escape_sequence_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit
// Backslash escape decoder: one character word in, zero to two result words out.
// ----------------------------------------------------------------------------
// path: input register, combinational decode, result queue driving the output
// throughput: one character per cycle while the result queue has room for two words; an
//   item with two results sends two words, and the four-entry queue bounds input run-ahead
// reset: synchronous, active high; clears decode state, escape enable and the queue
module escape_sequence_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   esd_req_if.sink    req_chan,
   esd_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import esd_pkg::*;

   logic                 enable_ff;
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [CHAR_IN_W-1:0] in_char_ff;
   logic                 in_last_ff;
   dec_state_type        state_ff;
   dec_state_type        state_in;

   logic                   req_take;
   logic                   step_go;
   logic [1:0]             word_cnt;
   logic [1:0]             push_cnt;
   rsp_word_type           word0;
   rsp_word_type           word1;
   rsp_word_type           head;
   logic [QUEUE_CNT_W-1:0] q_count;
   logic                   rsp_pop;

   // step only when the queue can take two words
   assign step_go  = in_valid_ff && (q_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign req_chan.ready = !in_valid_ff || step_go;
   assign req_take = req_chan.valid && req_chan.ready;
   assign in_valid_in = req_take || (in_valid_ff && !step_go);
   assign push_cnt = step_go ? word_cnt : 2'd0;

   esd_decode u_decode (
      .enable     (enable_ff),
      .char_in    (in_char_ff),
      .token_last (in_last_ff),
      .cur        (state_ff),
      .nxt        (state_in),
      .word_cnt   (word_cnt),
      .word0      (word0),
      .word1      (word1)
   );

   esd_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_cnt (push_cnt),
      .push0    (word0),
      .push1    (word1),
      .pop      (rsp_pop),
      .head     (head),
      .count    (q_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         in_valid_ff  <= 1'b0;
         state_ff     <= '{mode: MODE_NORMAL, acc: '0, digits: '0};
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         in_valid_ff <= in_valid_in;
         if (step_go) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_chan.char_in;
         in_last_ff <= req_chan.token_last;
      end
   end

   assign rsp_chan.valid      = (q_count != '0);
   assign rsp_chan.char_out   = head.char_out;
   assign rsp_chan.char_valid = head.char_valid;
   assign rsp_chan.token_end  = head.token_end;
   assign rsp_pop = rsp_chan.valid && rsp_chan.ready;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_last_words: assert property (@(posedge clock) disable iff (reset)
      step_go && in_last_ff |-> word_cnt != 2'd0)
      else $error("token end produced no word");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step_go && in_last_ff |=> state_ff.mode == MODE_NORMAL && state_ff.acc == '0)
      else $error("state not cleared at token end");

   a_bare_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.char_valid |-> rsp_chan.token_end && rsp_chan.char_out == '0)
      else $error("bare mark outside token end");

endmodule

// ===== tb/sv/escape_sequence_decoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder_unit_test
// Drives character words into the escape decoder and follows each accepted
// word with a predictor of the decode state. Every result word is compared
// field by field with the oldest predicted one. Directed tokens cover letter,
// octal, fixed and braced hex escapes, token ends and pass-through mode.
// Random tokens then follow, mostly well formed, under random idling on
// both channels.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_unit_test;
   import esd_pkg::*;

   localparam logic [CHAR_IN_W-1:0] CHAR_MAX = 21'h10FFFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   esd_req_if req_chan ();
   esd_rsp_if rsp_chan ();

   escape_sequence_decoder_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // predictor state
   mode_type              dec_mode;
   logic [CHAR_OUT_W-1:0] code_acc;
   logic [DIGIT_W-1:0]    digits_left;
   logic                  escapes_on;

   rsp_word_type step_words[$];
   rsp_word_type awaited_words[$];

   int mismatches = 0;
   int chars_sent = 0;
   int req_gap_max = 3;
   int rsp_stall_max = 3;
   int stall_left = 0;

   function automatic bit hex_digit(input logic [CHAR_IN_W-1:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
         v = c[3:0];
         return 1'b1;
      end
      if (c >= CH_UP_A && c <= CH_UP_F) begin
         v = 4'(c - CH_UP_A + 21'd10);
         return 1'b1;
      end
      if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         v = 4'(c - CH_LOW_A + 21'd10);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void put_word(input logic [CHAR_OUT_W-1:0] v, input logic ok);
      rsp_word_type w;
      if (step_words.size() >= 2) return;
      w.char_out   = v;
      w.char_valid = ok;
      w.token_end  = 1'b0;
      step_words.push_back(w);
   endfunction

   function void text_char(input logic [CHAR_IN_W-1:0] c);
      if (c == CH_BACKSLASH) begin
         dec_mode = MODE_ESC;
      end else begin
         dec_mode = MODE_NORMAL;
         put_word(32'(c), 1'b1);
      end
   endfunction

   function void escape_char(input logic [CHAR_IN_W-1:0] c);
      code_acc = '0;
      dec_mode = MODE_NORMAL;
      case (c)
         CH_LOW_A: put_word(CODE_BEL, 1'b1);
         CH_LOW_B: put_word(CODE_BS, 1'b1);
         CH_LOW_E: put_word(CODE_ESC, 1'b1);
         CH_LOW_F: put_word(CODE_FF, 1'b1);
         CH_LOW_N: put_word(CODE_LF, 1'b1);
         CH_LOW_R: put_word(CODE_CR, 1'b1);
         CH_LOW_T: put_word(CODE_HT, 1'b1);
         CH_LOW_V: put_word(CODE_VT, 1'b1);
         CH_LOW_X, CH_UP_X: begin
            digits_left = DIGITS_X;
            dec_mode    = MODE_HEXSEL;
         end
         CH_LOW_U: begin
            digits_left = DIGITS_U;
            dec_mode    = MODE_HEXSEL;
         end
         CH_UP_U: begin
            digits_left = DIGITS_W;
            dec_mode    = MODE_HEXSEL;
         end
         default: begin
            if (c >= CH_DIG_0 && c <= CH_DIG_7) begin
               code_acc = {29'd0, c[2:0]};
               dec_mode = MODE_OCT;
            end else begin
               put_word(32'(c), 1'b1);
            end
         end
      endcase
   endfunction

   function void fixed_hex_char(input logic [CHAR_IN_W-1:0] c);
      logic [3:0] v;
      if (hex_digit(c, v) && digits_left != 0) begin
         code_acc    = {code_acc[27:0], v};
         digits_left = digits_left - 4'd1;
         if (digits_left == 0) begin
            put_word(code_acc, 1'b1);
            code_acc = '0;
            dec_mode = MODE_NORMAL;
         end else begin
            dec_mode = MODE_HEXFIX;
         end
      end else begin
         put_word(code_acc, 1'b1);
         code_acc = '0;
         text_char(c);
      end
   endfunction

   // works out the result words of one accepted character word
   function void decode_char(input logic [CHAR_IN_W-1:0] c, input logic last);
      logic [3:0]   v;
      rsp_word_type w;
      step_words.delete();
      if (!escapes_on) begin
         dec_mode    = MODE_NORMAL;
         code_acc    = '0;
         digits_left = '0;
         put_word(32'(c), 1'b1);
      end else begin
         case (dec_mode)
            MODE_ESC: escape_char(c);
            MODE_OCT: begin
               if (c >= CH_DIG_0 && c <= CH_DIG_7) begin
                  code_acc = {code_acc[28:0], c[2:0]};
               end else begin
                  put_word(code_acc, 1'b1);
                  code_acc = '0;
                  text_char(c);
               end
            end
            MODE_HEXSEL: begin
               if (c == CH_LBRACE) dec_mode = MODE_HEXBRACE;
               else fixed_hex_char(c);
            end
            MODE_HEXFIX: fixed_hex_char(c);
            MODE_HEXBRACE: begin
               if (hex_digit(c, v)) begin
                  code_acc = {code_acc[27:0], v};
               end else begin
                  put_word(code_acc, 1'b1);
                  code_acc = '0;
                  if (c == CH_RBRACE) dec_mode = MODE_NORMAL;
                  else text_char(c);
               end
            end
            default: text_char(c);
         endcase
      end
      if (last) begin
         if (dec_mode inside {MODE_OCT, MODE_HEXSEL, MODE_HEXFIX, MODE_HEXBRACE})
            put_word(code_acc, 1'b1);
         dec_mode    = MODE_NORMAL;
         code_acc    = '0;
         digits_left = '0;
         if (step_words.size() == 0) put_word('0, 1'b0);
         w = step_words.pop_back();
         w.token_end = 1'b1;
         step_words.push_back(w);
      end
      foreach (step_words[i]) awaited_words.push_back(step_words[i]);
   endfunction

   // result side: random stall per word, compare against the oldest prediction
   always @(posedge clock) begin : check_words
      rsp_word_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got %h %b %b",
                     $time, rsp_chan.char_out, rsp_chan.char_valid, rsp_chan.token_end);
            mismatches++;
         end else begin
            w = awaited_words.pop_front();
            if (rsp_chan.char_out !== w.char_out) begin
               $display("%0t: char_out expected %h got %h", $time, w.char_out, rsp_chan.char_out);
               mismatches++;
            end
            if (rsp_chan.char_valid !== w.char_valid) begin
               $display("%0t: char_valid expected %b got %b", $time, w.char_valid,
                        rsp_chan.char_valid);
               mismatches++;
            end
            if (rsp_chan.token_end !== w.token_end) begin
               $display("%0t: token_end expected %b got %b", $time, w.token_end,
                        rsp_chan.token_end);
               mismatches++;
            end
         end
         stall_left = $urandom_range(0, rsp_stall_max);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_char(input logic [CHAR_IN_W-1:0] c, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.char_in    <= c;
      req_chan.token_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      decode_char(c, last);
      chars_sent++;
   endtask

   // drain all results, then give a word with no result time to leave the pipe
   task automatic go_idle();
      req_chan.valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_escapes(input logic en);
      go_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= en;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      escapes_on = en;
   endtask

   function automatic logic [CHAR_IN_W-1:0] pick_hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return CH_DIG_0 + 21'(v);
      if ($urandom_range(0, 1)) return CH_UP_A + 21'(v - 10);
      return CH_LOW_A + 21'(v - 10);
   endfunction

   function automatic logic [CHAR_IN_W-1:0] pick_text_char();
      case ($urandom_range(0, 9))
         0: return 21'($urandom_range(0, CHAR_MAX));
         1: return pick_hex_char();
         2: return CH_DIG_0 + 21'($urandom_range(0, 9));
         3: return $urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE;
         default: return 21'($urandom_range(32, 126));
      endcase
   endfunction

   // one token built from random pieces, mostly well-formed escapes
   task automatic send_random_token();
      logic [CHAR_IN_W-1:0] tok[$];
      logic [CHAR_IN_W-1:0] sel;
      int lim;
      int kind;
      if ($urandom_range(0, 19) == 0) begin
         req_gap_max   = $urandom_range(0, 1) ? 3 : 0;
         rsp_stall_max = $urandom_range(0, 1) ? 3 : 0;
      end
      repeat ($urandom_range(1, 5)) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1: tok.push_back(pick_text_char());
            2: begin
               tok.push_back(CH_BACKSLASH);
               case ($urandom_range(0, 7))
                  0: tok.push_back(CH_LOW_A);
                  1: tok.push_back(CH_LOW_B);
                  2: tok.push_back(CH_LOW_E);
                  3: tok.push_back(CH_LOW_F);
                  4: tok.push_back(CH_LOW_N);
                  5: tok.push_back(CH_LOW_R);
                  6: tok.push_back(CH_LOW_T);
                  default: tok.push_back(CH_LOW_V);
               endcase
            end
            3: begin
               tok.push_back(CH_BACKSLASH);
               tok.push_back(pick_text_char());
            end
            4: begin
               // long runs wrap the 32-bit value
               tok.push_back(CH_BACKSLASH);
               lim = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
               repeat (lim) tok.push_back(CH_DIG_0 + 21'($urandom_range(0, 7)));
            end
            5, 6, 7, 8: begin
               tok.push_back(CH_BACKSLASH);
               case ($urandom_range(0, 3))
                  0: begin sel = CH_LOW_X; lim = 2; end
                  1: begin sel = CH_UP_X;  lim = 2; end
                  2: begin sel = CH_LOW_U; lim = 4; end
                  default: begin sel = CH_UP_U; lim = 8; end
               endcase
               tok.push_back(sel);
               if (kind < 7) begin
                  repeat ($urandom_range(0, lim)) tok.push_back(pick_hex_char());
               end else begin
                  tok.push_back(CH_LBRACE);
                  repeat ($urandom_range(0, 12)) tok.push_back(pick_hex_char());
                  if ($urandom_range(0, 4) != 0) tok.push_back(CH_RBRACE);
               end
            end
            default: tok.push_back(CH_BACKSLASH);
         endcase
      end
      foreach (tok[i]) send_char(tok[i], i == tok.size() - 1);
   endtask

   task automatic test_passthrough();
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CHAR_MAX, 1'b0);
      send_char('0, 1'b1);
   endtask

   task automatic test_letter_escapes();
      // \e then an escaped backslash
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_LOW_E, 1'b0);
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_BACKSLASH, 1'b1);
   endtask

   task automatic test_fixed_hex();
      // one digit then a stop letter, then \x with no digits at token end
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_LOW_X, 1'b0);
      send_char(CH_DIG_0 + 21'd4, 1'b0);
      send_char(21'h47, 1'b0);
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_LOW_X, 1'b1);
   endtask

   task automatic test_braced_hex();
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_LOW_U, 1'b0);
      send_char(CH_LBRACE, 1'b0);
      send_char(CH_LOW_A, 1'b0);
      send_char(CH_UP_F, 1'b0);
      send_char(CH_RBRACE, 1'b1);
      // empty braces closed by a non-hex character
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_UP_U, 1'b0);
      send_char(CH_LBRACE, 1'b0);
      send_char(21'h7A, 1'b1);
   endtask

   task automatic test_octal();
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_DIG_7, 1'b0);
      send_char(CH_DIG_7, 1'b0);
      send_char(CH_DIG_0 + 21'd8, 1'b1);
   endtask

   task automatic test_lone_backslash();
      send_char(CH_BACKSLASH, 1'b1);
   endtask

   task automatic test_random_tokens(input int target);
      while (chars_sent < target) send_random_token();
   endtask

   // pending hex value is dropped when escapes go off
   task automatic test_disable_mid_token(input int target);
      send_char(CH_BACKSLASH, 1'b0);
      send_char(CH_LOW_X, 1'b0);
      send_char(CH_DIG_0 + 21'd4, 1'b0);
      set_escapes(1'b0);
      test_random_tokens(target);
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.char_in    = '0;
      req_chan.token_last = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      dec_mode            = MODE_NORMAL;
      code_acc            = '0;
      digits_left         = '0;
      escapes_on          = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_passthrough();
      set_escapes(1'b1);
      test_letter_escapes();
      test_fixed_hex();
      test_braced_hex();
      test_octal();
      test_lone_backslash();
      test_random_tokens(1200);
      test_disable_mid_token(1400);
      set_escapes(1'b1);
      test_random_tokens(1850);

      req_chan.valid <= 1'b0;
      for (int k = 0; k < 1000 && awaited_words.size() != 0; k++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_words.size() != 0) begin
         $display("%0t: %0d decoded words never arrived", $time, awaited_words.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("escape_sequence_decoder_unit verification clean");
      end else begin
         $display("escape_sequence_decoder_unit verification failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("escape_sequence_decoder_unit verification failed");
      $finish;
   end

endmodule
